// File: rtl/distinct_value_counter_top_assert.svh
// Assertion macros for the checker file.
`ifndef DISTINCT_VALUE_COUNTER_TOP_ASSERT_SVH
`define DISTINCT_VALUE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define DVC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define DVC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dvc_pkg.sv
package dvc_pkg;

  localparam int REQ_W   = 2;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 6;

  // Stream widths; tdata is padded to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 3;

  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic read_issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             occ_zero;
    logic             idx_in_range;
    logic             match;
    logic             scan_miss;
    logic             out_free;
  } status_t;

endpackage

// File: rtl/distinct_value_counter_top.sv
// channel | direction | tdata (low bit up)                          | tuser (low bit up)
// s       | in        | value[31:0], index[36:32], zero pad        | req_type[1:0]
// m       | out       | entry_value[31:0], entry_count[47:32],     | hit, dropped,
//         |           | distinct_total[53:48], zero pad            | entry_valid
//
// Reads, clears, unused codes and counts on an empty table skip the search; any other
// count searches the stored entries oldest first, stopping at a match. The search
// reads one stored entry per cycle through the single read port of the entry memory.
// Reset clears the occupancy; entry contents need no clearing. A result waits in the
// output register; a stalled m side holds the block in its final state, s_tready low.
module distinct_value_counter_top #(
  parameter int ENTRIES    = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dvc_pkg::S_TDATA_W-1:0]  s_tdata,   // value, index
  input  logic [dvc_pkg::S_TUSER_W-1:0]  s_tuser,   // req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dvc_pkg::M_TDATA_W-1:0]  m_tdata,   // entry_value, entry_count, distinct_total
  output logic [dvc_pkg::M_TUSER_W-1:0]  m_tuser    // hit, dropped, entry_valid
);
  import dvc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  dvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dvc_datapath #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/dvc_ctrl.sv
module dvc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  dvc_pkg::status_t sts,
  output dvc_pkg::cmd_t    cmd
);
  import dvc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DISPATCH = 4'b0010,
    ST_SCAN     = 4'b0100,
    ST_FINISH   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.req == REQ_COUNT && !sts.occ_zero) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          if (sts.req == REQ_READ && sts.idx_in_range) begin
            cmd.read_issue = 1'b1;
          end
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        // hold the read data once the search resolves
        if (sts.match || sts.scan_miss) begin
          state_next = ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dvc_datapath.sv
module dvc_datapath #(
  parameter int ENTRIES    = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dvc_pkg::cmd_t                  cmd,
  output dvc_pkg::status_t               sts,
  input  logic [dvc_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [dvc_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dvc_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [dvc_pkg::M_TUSER_W-1:0]  m_tuser
);
  import dvc_pkg::*;

  localparam int SW = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > INDEX_W) ? OW : INDEX_W;
  localparam int MW = SW + COUNT_W;
  localparam logic [OW-1:0] FULL = OW'(ENTRIES);

  // Request held for the whole step.
  logic [REQ_W-1:0]   req;
  logic [SW-1:0]      val;
  logic [INDEX_W-1:0] idx;

  logic [OW-1:0] occ;
  logic [OW-1:0] occ_next;
  logic [AW-1:0] ptr;
  logic          issuing;
  logic          rd_live;
  logic          rd_last;
  logic [AW-1:0] rd_slot;

  // Entry store: value in the upper bits, count in the lower.
  logic [MW-1:0] mem [ENTRIES];
  logic [MW-1:0] rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_req;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  logic [OW-1:0]      occ_m1;
  logic               idx_in_range;
  logic [AW-1:0]      read_slot;
  logic [SW-1:0]      rd_val;
  logic [COUNT_W-1:0] rd_cnt;
  logic [COUNT_W-1:0] cnt_inc;
  logic               equal;
  logic               match;
  logic               ptr_last;
  logic               full;

  logic               res_hit;
  logic               res_drop;
  logic               res_valid;
  logic [DATA_W-1:0]  res_value;
  logic [COUNT_W-1:0] res_count;

  logic               o_hit;
  logic               o_drop;
  logic               o_valid;
  logic [DATA_W-1:0]  o_value;
  logic [COUNT_W-1:0] o_count;
  logic [TOTAL_W-1:0] o_total;

  assign occ_m1       = occ - OW'(1);
  assign idx_in_range = CW'(idx) < CW'(occ);
  assign read_slot    = AW'(CW'(occ) - CW'(1) - CW'(idx));
  assign rd_val       = rdata[MW-1:COUNT_W];
  assign rd_cnt       = rdata[COUNT_W-1:0];
  assign cnt_inc      = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
  assign equal        = (rd_val == val);
  assign match        = rd_live && equal;
  assign ptr_last     = (OW'(ptr) == occ_m1);
  assign full         = (occ == FULL);

  assign sts.req          = req;
  assign sts.occ_zero     = (occ == '0);
  assign sts.idx_in_range = idx_in_range;
  assign sts.match        = match;
  assign sts.scan_miss    = rd_live && rd_last && !equal;
  assign sts.out_free     = !m_tvalid || m_tready;

  assign rd_en   = (cmd.scan_step && issuing) || cmd.read_issue;
  assign rd_addr = cmd.read_issue ? read_slot : ptr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= s_tuser[REQ_W-1:0];
      val <= s_tdata[SW-1:0];
      idx <= s_tdata[DATA_W +: INDEX_W];
    end
    if (cmd.scan_step && issuing) begin
      rd_slot <= ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      issuing <= 1'b0;
      rd_live <= 1'b0;
      rd_last <= 1'b0;
    end else if (cmd.load) begin
      issuing <= 1'b0;
      rd_live <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr     <= '0;
      issuing <= 1'b1;
      rd_live <= 1'b0;
      rd_last <= 1'b0;
    end else if (cmd.read_issue) begin
      rd_live <= 1'b1;
      rd_last <= 1'b1;
    end else if (cmd.scan_step) begin
      rd_live <= issuing;
      rd_last <= ptr_last;
      if (issuing) begin
        if (ptr_last) begin
          issuing <= 1'b0;
        end else begin
          ptr <= ptr + AW'(1);
        end
      end
    end
  end

  always_comb begin
    res_hit   = 1'b0;
    res_drop  = 1'b0;
    res_valid = 1'b0;
    res_value = '0;
    res_count = '0;
    occ_next  = occ;
    wr_req    = 1'b0;
    wr_addr   = occ[AW-1:0];
    wr_data   = {val, COUNT_W'(1)};
    case (req)
      REQ_COUNT: begin
        res_value = DATA_W'(val);
        if (match) begin
          res_hit   = 1'b1;
          res_valid = 1'b1;
          res_count = cnt_inc;
          wr_req    = 1'b1;
          wr_addr   = rd_slot;
          wr_data   = {val, cnt_inc};
        end else if (full) begin
          res_drop = 1'b1;
        end else begin
          // append as the newest entry
          res_valid = 1'b1;
          res_count = COUNT_W'(1);
          wr_req    = 1'b1;
          occ_next  = occ + OW'(1);
        end
      end
      REQ_READ: begin
        if (idx_in_range) begin
          res_valid = 1'b1;
          res_value = DATA_W'(rd_val);
          res_count = rd_cnt;
        end
      end
      REQ_CLEAR: begin
        occ_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_req) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        occ      <= occ_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_hit   <= res_hit;
      o_drop  <= res_drop;
      o_valid <= res_valid;
      o_value <= res_value;
      o_count <= res_count;
      o_total <= TOTAL_W'(occ_next);
    end
  end

  assign m_tdata = {2'b00, o_total, o_count, o_value};
  assign m_tuser = {o_valid, o_drop, o_hit};

endmodule

// File: rtl/dvc_checker.sv
`include "distinct_value_counter_top_assert.svh"

module dvc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dvc_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [dvc_pkg::M_TUSER_W-1:0] m_tuser
);
  import dvc_pkg::*;

  localparam int HIT_BIT   = 0;
  localparam int DROP_BIT  = 1;
  localparam int VALID_BIT = 2;

  logic [COUNT_W-1:0] count;

  assign count = m_tdata[DATA_W +: COUNT_W];

  `DVC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

  `DVC_ASSERT_IMPL(a_hit_drop, m_tvalid, !(m_tuser[HIT_BIT] && m_tuser[DROP_BIT]), "hit and dropped together")

  `DVC_ASSERT_IMPL(a_drop_empty, m_tvalid && m_tuser[DROP_BIT], !m_tuser[VALID_BIT] && count == '0, "dropped word carries an entry")

  `DVC_ASSERT_IMPL(a_valid_count, m_tvalid && (m_tuser[VALID_BIT] || m_tuser[HIT_BIT]), m_tuser[VALID_BIT] && count != '0, "stored entry with zero count")

endmodule

bind distinct_value_counter_top dvc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
